// ===== design/top_k_index_select_macros.svh =====
// Assertion macros shared by the top-k index selection design.
// Each macro expects a signal named clk in the enclosing module; TKIS_ASSERT also expects rst_n.
`ifndef TOP_K_INDEX_SELECT_MACROS_SVH
`define TOP_K_INDEX_SELECT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TKIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define TKIS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tkis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkis_pkg;

  // Depth of the kept list and the stream length that can be numbered.
  localparam int MAX_K     = 16;
  localparam int MAX_ITEMS = 65536;

  // Field widths.
  localparam int SCORE_W = 32;
  localparam int POS_W   = 16;
  localparam int TC_W    = 5;

  // The arrival counter saturates at LIMIT.
  localparam int POS_SPACE = 65536;
  localparam int LIMIT     = (MAX_ITEMS < POS_SPACE) ? MAX_ITEMS : POS_SPACE;
  localparam int CNT_W     = $clog2(LIMIT + 1);

  // Width of a count of reported positions, 0 to MAX_K.
  localparam int RW = $clog2(MAX_K + 1);

  // Reset value of top_count.
  localparam logic [TC_W-1:0] TOP_COUNT_RESET = TC_W'(5);

  // One kept entry of the list.
  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [POS_W-1:0]          pos;
  } entry_t;

  // What a cell hands to its lower neighbour: its entry and whether it takes the new score.
  typedef struct packed {
    entry_t ent;
    logic   take;
  } link_t;

endpackage

`default_nettype wire

// ===== design/tkis_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkis_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ins_en,
  input  logic            clr,
  input  tkis_pkg::entry_t new_ent,
  input  tkis_pkg::link_t  prev_i,
  output tkis_pkg::link_t  link_o,
  output tkis_pkg::entry_t nxt_o
);
  import tkis_pkg::*;

  logic                      valid_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [POS_W-1:0]          pos_r;
  entry_t                    cur;
  entry_t                    ent_nxt;
  logic                      take;

  assign cur = '{valid: valid_r, score: score_r, pos: pos_r};

  // An empty slot, or one holding a strictly lower score, yields to the new score.
  assign take = !valid_r || ($signed(new_ent.score) > $signed(score_r));

  // The cell above taking means everything from here down moves one place lower.
  always_comb begin
    ent_nxt = cur;
    if (ins_en && prev_i.take) begin
      ent_nxt = prev_i.ent;
    end else if (ins_en && take) begin
      ent_nxt = new_ent;
    end
  end

  assign link_o = '{ent: cur, take: take};
  assign nxt_o  = ent_nxt;

  // Valid bit: cleared by reset and at the end of every stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  // Payload of the slot.
  always_ff @(posedge clk) begin
    score_r <= ent_nxt.score;
    pos_r   <= ent_nxt.pos;
  end

endmodule

`default_nettype wire

// ===== design/tkis_drain.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_index_select_macros.svh"

module tkis_drain (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load_i,
  input  tkis_pkg::entry_t [tkis_pkg::MAX_K-1:0] snap_i,
  input  logic [tkis_pkg::RW-1:0]                want_i,
  input  logic                                   ovf_i,
  input  logic                                   out_tready,
  output logic                                   out_tvalid,
  output logic [15:0]                            out_tdata,  // position
  output logic                                   out_tlast,  // final_result
  output logic                                   out_tuser,  // stream_too_long
  output logic                                   free_o
);
  import tkis_pkg::*;

  logic [MAX_K-1:0]            d_valid_r, d_valid_nxt;
  logic [MAX_K-1:0][POS_W-1:0] d_pos_r, d_pos_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [MAX_K:0]              vext;
  logic [MAX_K:0][POS_W-1:0]   pext;
  logic                        busy;
  logic                        fin;
  logic                        pop;

  assign vext = {1'b0, d_valid_r};
  assign pext = {POS_W'(0), d_pos_r};

  // The head cell is shown while positions remain to be reported.
  assign busy = d_valid_r[0] && (rem_r != '0);
  assign fin  = (rem_r == RW'(1)) || !vext[1];
  assign pop  = busy && out_tready;

  // A new report may be loaded once the present one has gone or goes now.
  assign free_o = !busy || (pop && fin);

  // Each transfer moves the row of cells one place towards the head.
  always_comb begin
    d_valid_nxt = d_valid_r;
    d_pos_nxt   = d_pos_r;
    rem_nxt     = rem_r;
    ovf_nxt     = ovf_r;
    if (pop) begin
      d_valid_nxt = vext[MAX_K:1];
      d_pos_nxt   = pext[MAX_K:1];
      rem_nxt     = rem_r - RW'(1);
    end
    if (load_i) begin
      for (int i = 0; i < MAX_K; i++) begin
        d_valid_nxt[i] = snap_i[i].valid;
        d_pos_nxt[i]   = snap_i[i].pos;
      end
      rem_nxt = want_i;
      ovf_nxt = ovf_i;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= '0;
      rem_r     <= '0;
    end else begin
      d_valid_r <= d_valid_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    d_pos_r <= d_pos_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_tvalid = busy;
  assign out_tdata  = d_pos_r[0];
  assign out_tlast  = fin;
  assign out_tuser  = ovf_r;

  `TKIS_ASSERT(a_load_when_free, !(load_i && !free_o), "report loaded over an unfinished one")
  `TKIS_ASSERT(a_drain_prefix, ((d_valid_r >> 1) & ~d_valid_r) == '0, "drain cells not a prefix")
  `TKIS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result shown after reset")

endmodule

`default_nettype wire

// ===== design/top_k_index_select.sv =====
// Top-k index selection: one score transfer per cycle, inserted into a sorted row of cells.
// The first position of a report is offered in the cycle after the last score's transfer.
// Throughput: one score per cycle; a report gives one position per cycle with out_tready high.
// A last score waits while an earlier report is still draining; other scores never wait.
// Reset (synchronous, rst_n low) empties the list and the drain, zeroes the counter and
// sets top_count to 5.
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_index_select_macros.svh"

module top_k_index_select (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tkis_pkg::TC_W-1:0] cfg_wr_data,  // top_count
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,     // score
  input  logic                      in_tlast,     // end_of_stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,    // position
  output logic                      out_tlast,    // final_result
  output logic                      out_tuser     // stream_too_long
);
  import tkis_pkg::*;

  logic [TC_W-1:0]         top_count_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    in_xfer;
  logic                    ranked;
  logic                    last_xfer;
  logic                    drain_free;
  logic [RW-1:0]           want;
  entry_t                  new_ent;
  link_t [MAX_K:0]         chain;
  entry_t [MAX_K-1:0]      snap;
  logic [MAX_K-1:0]        cell_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      top_count_r <= cfg_wr_data;
    end
  end

  // A last score is only taken when the drain can accept its report.
  assign in_tready = !in_tlast || drain_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign last_xfer = in_xfer && in_tlast;
  assign ranked    = (cnt_r != CNT_W'(LIMIT));

  assign new_ent = '{valid: 1'b1, score: $signed(in_tdata), pos: POS_W'(cnt_r)};

  // Arrival counter and long-stream flag.
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (in_xfer) begin
      if (ranked) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (last_xfer) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Row of insertion cells, best score in cell 0.
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    tkis_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ins_en  (in_xfer && ranked),
      .clr     (last_xfer),
      .new_ent (new_ent),
      .prev_i  (chain[g]),
      .link_o  (chain[g+1]),
      .nxt_o   (snap[g])
    );
    assign cell_valid[g] = chain[g+1].ent.valid;
  end

  // Number of positions to report, limited to the depth of the list.
  always_comb begin
    if (32'(top_count_r) > MAX_K) begin
      want = RW'(MAX_K);
    end else begin
      want = RW'(top_count_r);
    end
  end

  // Report drain, loaded with the list as it stands after the last score.
  tkis_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (last_xfer),
    .snap_i     (snap),
    .want_i     (want),
    .ovf_i      (ovf_nxt),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .free_o     (drain_free)
  );

  `TKIS_ASSERT(a_list_prefix, ((cell_valid >> 1) & ~cell_valid) == '0, "kept list not a prefix")
  `TKIS_ASSERT(a_cnt_limit, cnt_r <= CNT_W'(LIMIT), "arrival counter beyond its limit")

endmodule

`default_nettype wire

// ===== test/top_k_checker.sv =====
`timescale 1ns / 1ps

module top_k_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tkis_pkg::TC_W-1:0] cfg_wr_data,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [31:0]               in_tdata,
  input  logic                      in_tlast,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [15:0]               out_tdata,
  input  logic                      out_tlast,
  input  logic                      out_tuser,
  output int                        mismatch_count,
  output int                        pending_reports
);
  import tkis_pkg::*;

  // One reported position as it should leave the block.
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             final_result;
    logic             too_long;
  } report_t;

  report_t expected_reports[$];

  // Own copy of the ranked list; entries at and beyond ranked_fill are only shifted, never compared or reported.
  logic signed [SCORE_W-1:0] ranked_score [MAX_K];
  logic [POS_W-1:0]          ranked_pos   [MAX_K];
  int                        ranked_fill = 0;
  int                        arrivals = 0;
  logic                      overflow_seen = 1'b0;
  logic [TC_W-1:0]           top_count = TOP_COUNT_RESET;

  int mismatches = 0;
  int queued_reports = 0;

  assign mismatch_count  = mismatches;
  assign pending_reports = queued_reports;

  // A new score goes below every kept score that is greater or equal; the list keeps MAX_K.
  task automatic rank_score(input logic signed [SCORE_W-1:0] score,
                            input logic [POS_W-1:0] position);
    int slot;
    slot = 0;
    while (slot < ranked_fill && ranked_score[slot] >= score) slot++;
    if (slot < MAX_K) begin
      for (int i = MAX_K - 1; i > slot; i--) begin
        ranked_score[i] = ranked_score[i - 1];
        ranked_pos[i]   = ranked_pos[i - 1];
      end
      ranked_score[slot] = score;
      ranked_pos[slot]   = position;
      if (ranked_fill < MAX_K) ranked_fill++;
    end
  endtask

  // The end of a stream queues the best positions and empties the list.
  task automatic close_stream();
    int      wanted;
    int      count;
    report_t item;
    wanted = (top_count > MAX_K) ? MAX_K : int'(top_count);
    count  = (wanted < ranked_fill) ? wanted : ranked_fill;
    for (int i = 0; i < count; i++) begin
      item.position     = ranked_pos[i];
      item.final_result = (i == count - 1);
      item.too_long     = overflow_seen;
      expected_reports.insert(expected_reports.size(), item);
    end
    ranked_fill   = 0;
    arrivals      = 0;
    overflow_seen = 1'b0;
  endtask

  // Follow every transfer on the three ports and compare each result with the oldest one due.
  always @(posedge clk) begin : watch
    report_t due;
    if (!rst_n) begin
      top_count     = TOP_COUNT_RESET;
      ranked_fill   = 0;
      arrivals      = 0;
      overflow_seen = 1'b0;
      expected_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (arrivals >= LIMIT) begin
          overflow_seen = 1'b1;
        end else begin
          rank_score(in_tdata, POS_W'(arrivals));
          arrivals++;
        end
        if (in_tlast) close_stream();
      end

      // The register takes its new value at this edge, after any report has been sized.
      if (cfg_wr_en) top_count = cfg_wr_data;

      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("position: expected no result, got %0d", out_tdata);
          mismatches++;
        end else begin
          due = expected_reports.pop_front();
          if (out_tdata !== due.position) begin
            $error("position: expected %0d, got %0d", due.position, out_tdata);
            mismatches++;
          end
          if (out_tlast !== due.final_result) begin
            $error("final_result: expected %0d, got %0d", due.final_result, out_tlast);
            mismatches++;
          end
          if (out_tuser !== due.too_long) begin
            $error("stream_too_long: expected %0d, got %0d", due.too_long, out_tuser);
            mismatches++;
          end
        end
      end
    end
    queued_reports <= expected_reports.size();
  end

endmodule

// ===== test/tb_top_k_index_select.sv =====
`timescale 1ns / 1ps

module tb_top_k_index_select;
  import tkis_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_GAP   = 4;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_wr_en = 1'b0;
  logic [TC_W-1:0] cfg_wr_data = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [31:0]     in_tdata = '0;
  logic            in_tlast = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b1;
  logic [15:0]     out_tdata;
  logic            out_tlast;
  logic            out_tuser;

  int mismatch_count;
  int pending_reports;
  int idle_cycles = 0;
  int scores_sent = 0;
  bit calm = 1'b0;

  top_k_index_select dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  top_k_checker report_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .pending_reports (pending_reports)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ends the run when no transfer has happened on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the quiet last part of the run.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Offers one score and waits for its transfer; valid stays high unless a gap follows.
  task automatic send_score(input logic [31:0] score, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= score;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scores_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every report has left the block.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_top_count(input logic [TC_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly full-range scores, with extremes and a crowd of values near zero for ties.
  function automatic logic [31:0] random_score();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TC_W-1:0] random_top_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TC_W'($urandom_range(MAX_K + 1, 31));
      default: return TC_W'($urandom_range(1, MAX_K));
    endcase
  endfunction

  // A stream of random length, mostly short, sometimes longer than the list.
  task automatic random_stream();
    int len;
    if ($urandom_range(0, 3) == 0) write_top_count(random_top_count());
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_K - 7, 30) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) send_score(random_score(), i == len - 1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the score range and a tie, reported with the count left at reset.
    send_score(32'h7fff_ffff, 1'b0);
    send_score(32'h8000_0000, 1'b0);
    send_score(32'h0000_0000, 1'b0);
    send_score(32'hffff_ffff, 1'b0);
    send_score(32'h7fff_ffff, 1'b1);

    // A stream of a single score.
    send_score(32'h8000_0000, 1'b1);

    // A count of zero ends the stream without any report.
    write_top_count('0);
    send_score(32'h0000_0005, 1'b1);

    // A count above the list depth, a full list, a dropped score and one that pushes out the lowest.
    write_top_count('1);
    for (int i = 0; i < 18; i++) begin
      if (i < MAX_K) begin
        send_score(32'(i % 4), 1'b0);
      end else if (i == MAX_K) begin
        send_score(32'hffff_ff00, 1'b0);
      end else begin
        send_score(32'd3, 1'b1);
      end
    end

    // The count written in the middle of a stream decides its report.
    write_top_count(TC_W'(MAX_K));
    send_score(32'h0000_0010, 1'b0);
    send_score(32'h0000_0020, 1'b0);
    write_top_count(TC_W'(2));
    send_score(32'h0000_0030, 1'b1);

    // Random streams with gaps on both sides, then a stretch without any.
    while (scores_sent < 400) random_stream();
    calm = 1'b1;
    while (scores_sent < 470) random_stream();

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== top_k_index_select.f =====
+incdir+design
design/tkis_pkg.sv
design/tkis_cell.sv
design/tkis_drain.sv
design/top_k_index_select.sv
test/top_k_checker.sv
test/tb_top_k_index_select.sv
